[rtl/png_up_row_predictor_unit_assert.svh]
// assertion macros for the png up row predictor unit
// expects clk and rst_n in the scope of use; no other dependencies
`ifndef PNG_UP_ROW_PREDICTOR_UNIT_ASSERT_SVH
`define PNG_UP_ROW_PREDICTOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PNGUP_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pngup assertion failed");
`define PNGUP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pngup assertion failed");
`else
`define PNGUP_ASSERT_IMPLIES(label, ante, cons)
`define PNGUP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/pngup_pkg.sv]
// shared types and constants for the png up row predictor
// no dependencies
package pngup_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 2'd2;

  localparam logic [7:0] UP_TAG = 8'd2;

  // result queue sizing
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_ENC,
    KIND_DEC_TAG,
    KIND_DEC_DATA
  } item_kind_t;

  typedef struct packed {
    logic [7:0] value;
    logic       mismatch;
    logic       last;
  } result_t;

  // up to two results enter the queue per cycle
  typedef struct packed {
    logic [1:0] cnt;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

[rtl/png_up_row_predictor_unit.sv]
// png up row predictor: previous row in a 1-read 1-write ram, result queue at the output
// first result reaches the output through the stage 1 registers and then the result queue
// throughput: 1 item per cycle while in_stall is low; encode rows of width 1 give 2 results per item, so the
// output port limits the item rate there; ram read-modify-write of one column per item
// reset: synchronous; a clearing pass then zeroes each of the ROW_MAX row ram entries in turn, in_stall high
// depends on pngup_pkg, pngup_res_queue and png_up_row_predictor_unit_assert.svh
`include "png_up_row_predictor_unit_assert.svh"

module png_up_row_predictor_unit #(
  parameter int ROW_MAX = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_byte,
  output logic                              out_tag_mismatch,
  output logic                              out_last,
  input  logic                              cfg_we,
  input  logic [pngup_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pngup_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int AW = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
  localparam int PW = $clog2(ROW_MAX + 1);
  localparam int CW = pngup_pkg::QCNT_W + 1;

  // configuration
  logic                              dir_r;
  logic                              mode_r;
  logic [pngup_pkg::CFG_DATA_W-1:0]  rw_r;

  // row state
  logic [PW-1:0]   pos_r, pos_nxt;
  logic            pend_r, pend_nxt;
  logic            clearing_r;
  logic [AW-1:0]   clr_cnt_r;

  // stage 1 (ram data available)
  logic                   s1_valid_r;
  pngup_pkg::item_kind_t  s1_kind_r;
  logic                   s1_tag_r;
  logic                   s1_mism_r;
  logic [7:0]             s1_byte_r;
  logic [AW-1:0]          s1_col_r;
  logic [1:0]             s1_n_r;
  logic                   s1_fwd_r;
  logic [7:0]             fwd_data_r;
  logic [7:0]             rdata_r;

  logic [7:0] mem [ROW_MAX];

  // stage 0 decode
  logic [31:0]            eff32;
  logic [PW-1:0]          w;
  logic [PW-1:0]          p_enc, p_dec;
  logic                   in_accept;
  pngup_pkg::item_kind_t  kind0;
  logic [AW-1:0]          col0;
  logic [1:0]             n0;
  logic                   tag0;
  logic                   mism0;

  // stage 1 datapath
  logic [7:0]          above;
  logic                s1_wr;
  logic [7:0]          diff, sum, wdata;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [7:0]          mem_wdata;
  pngup_pkg::push_t    push;
  pngup_pkg::result_t  head;
  logic [pngup_pkg::QCNT_W-1:0] q_count;
  logic [CW-1:0]       s1_cnt;

  always_comb begin
    if (rw_r == '0) begin
      eff32 = 32'd1;
    end else if (32'(rw_r) > 32'(ROW_MAX)) begin
      eff32 = 32'(ROW_MAX);
    end else begin
      eff32 = 32'(rw_r);
    end
  end
  assign w = PW'(eff32);

  assign p_enc = (pos_r >= w) ? '0 : pos_r;
  assign p_dec = (pos_r > w) ? '0 : pos_r;

  assign s1_cnt   = s1_valid_r ? CW'(s1_n_r) : '0;
  // room for what stage 1 pushes next edge plus a worst-case new item
  assign in_stall = clearing_r |
                    ((CW'(q_count) + s1_cnt + CW'(2)) > CW'(pngup_pkg::QDEPTH));
  assign in_accept = in_valid & ~in_stall;

  always_comb begin
    pos_nxt  = pos_r;
    pend_nxt = pend_r;
    kind0    = pngup_pkg::KIND_PASS;
    col0     = '0;
    n0       = 2'd1;
    tag0     = 1'b0;
    mism0    = 1'b0;
    if (mode_r) begin
      if (!dir_r) begin
        kind0   = pngup_pkg::KIND_ENC;
        col0    = AW'(p_enc);
        tag0    = (p_enc == '0);
        n0      = tag0 ? 2'd2 : 2'd1;
        pos_nxt = ((p_enc + PW'(1)) >= w) ? '0 : p_enc + PW'(1);
      end else if (p_dec == '0) begin
        // row tag byte: checked, no result
        kind0    = pngup_pkg::KIND_DEC_TAG;
        n0       = 2'd0;
        pend_nxt = (in_byte != pngup_pkg::UP_TAG);
        pos_nxt  = PW'(1);
      end else begin
        kind0    = pngup_pkg::KIND_DEC_DATA;
        col0     = AW'(p_dec - PW'(1));
        mism0    = pend_r;
        pend_nxt = 1'b0;
        pos_nxt  = (p_dec >= w) ? '0 : p_dec + PW'(1);
      end
    end
  end

  // stage 1: combine with the byte above, write back
  assign above = s1_fwd_r ? fwd_data_r : rdata_r;
  assign s1_wr = s1_valid_r & ((s1_kind_r == pngup_pkg::KIND_ENC) |
                               (s1_kind_r == pngup_pkg::KIND_DEC_DATA));
  assign diff  = s1_byte_r - above;
  assign sum   = s1_byte_r + above;
  assign wdata = (s1_kind_r == pngup_pkg::KIND_ENC) ? s1_byte_r : sum;

  assign mem_we    = clearing_r | s1_wr;
  assign mem_waddr = clearing_r ? clr_cnt_r : s1_col_r;
  assign mem_wdata = clearing_r ? 8'd0 : wdata;

  always_comb begin
    push.cnt    = 2'd0;
    push.first  = '{value: s1_byte_r, mismatch: 1'b0, last: 1'b1};
    push.second = '{value: diff, mismatch: 1'b0, last: 1'b1};
    if (s1_valid_r) begin
      case (s1_kind_r)
        pngup_pkg::KIND_PASS: begin
          push.cnt = 2'd1;
        end
        pngup_pkg::KIND_ENC: begin
          if (s1_tag_r) begin
            push.cnt   = 2'd2;
            push.first = '{value: pngup_pkg::UP_TAG, mismatch: 1'b0, last: 1'b0};
          end else begin
            push.cnt   = 2'd1;
            push.first = '{value: diff, mismatch: 1'b0, last: 1'b1};
          end
        end
        pngup_pkg::KIND_DEC_DATA: begin
          push.cnt   = 2'd1;
          push.first = '{value: sum, mismatch: s1_mism_r, last: 1'b1};
        end
        default: begin
          push.cnt = 2'd0;
        end
      endcase
    end
  end

  // row ram: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_accept) begin
      rdata_r <= mem[col0];
    end
  end

  // stage 1 payload; forward when stage 1 writes the column just read
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_kind_r  <= kind0;
      s1_tag_r   <= tag0;
      s1_mism_r  <= mism0;
      s1_byte_r  <= in_byte;
      s1_col_r   <= col0;
      s1_n_r     <= n0;
      s1_fwd_r   <= s1_wr & (s1_col_r == col0);
      fwd_data_r <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r      <= 1'b0;
      mode_r     <= 1'b0;
      rw_r       <= pngup_pkg::CFG_DATA_W'(1);
      pos_r      <= '0;
      pend_r     <= 1'b0;
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_accept;
      if (in_accept) begin
        pos_r  <= pos_nxt;
        pend_r <= pend_nxt;
      end
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(ROW_MAX - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          pngup_pkg::REG_DIRECTION: dir_r  <= cfg_wdata[0];
          pngup_pkg::REG_MODE:      mode_r <= cfg_wdata[0];
          pngup_pkg::REG_ROW_WIDTH: rw_r   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  pngup_res_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (head),
    .count     (q_count)
  );

  assign out_byte         = head.value;
  assign out_tag_mismatch = head.mismatch;
  assign out_last         = head.last;

  // the queue never takes more than it has room for
  `PNGUP_ASSERT_IMPLIES(a_queue_room, 1'b1, (CW'(q_count) + CW'(push.cnt)) <= (CW'(pngup_pkg::QDEPTH) + CW'(out_valid & ~out_stall)))
  // nothing flows while the row ram is being cleared
  `PNGUP_ASSERT_IMPLIES(a_clear_quiet, clearing_r, !out_valid && !s1_valid_r)
  // a row tag result always has its data byte queued behind it
  `PNGUP_ASSERT_IMPLIES(a_tag_pair, out_valid && !out_last, q_count >= pngup_pkg::QCNT_W'(2))

endmodule

[rtl/pngup_res_queue.sv]
// small result queue: takes up to two results a cycle, hands out one
// depends on pngup_pkg
module pngup_res_queue (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pngup_pkg::push_t               push,
  input  logic                           out_stall,
  output logic                           out_valid,
  output pngup_pkg::result_t             head,
  output logic [pngup_pkg::QCNT_W-1:0]   count
);

  pngup_pkg::result_t                 q_r [pngup_pkg::QDEPTH];
  logic [pngup_pkg::QPTR_W-1:0]       wp_r;
  logic [pngup_pkg::QPTR_W-1:0]       rp_r;
  logic [pngup_pkg::QCNT_W-1:0]       cnt_r;
  logic                               pop;

  assign out_valid = (cnt_r != '0);
  assign head      = q_r[rp_r];
  assign count     = cnt_r;
  assign pop       = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      q_r[wp_r] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      q_r[wp_r + pngup_pkg::QPTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + pngup_pkg::QPTR_W'(push.cnt);
      rp_r  <= rp_r + pngup_pkg::QPTR_W'(pop);
      cnt_r <= cnt_r + pngup_pkg::QCNT_W'(push.cnt) - pngup_pkg::QCNT_W'(pop);
    end
  end

endmodule
